// ===== hw/rtl/exposure_timestamp_corrector_macros.svh =====
// Assertion helpers shared by the timestamp corrector modules
`ifndef EXPOSURE_TIMESTAMP_CORRECTOR_MACROS_SVH
`define EXPOSURE_TIMESTAMP_CORRECTOR_MACROS_SVH

// same-cycle implication
`define ETC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define ETC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

// fixed-delay implication
`define ETC_ASSERT_DELAY(label, clk, rst_n, ante, dly, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##dly (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/etc_pkg.sv =====
package etc_pkg;

	localparam int ROW_BITS   = 16;
	localparam int SPAN_BITS  = 63;
	localparam int TIME_BITS  = 64;
	localparam int DIV_STAGES = TIME_BITS;
	localparam int PROD_BITS  = SPAN_BITS + ROW_BITS;
	localparam int LO_BITS    = 32;
	localparam int HI_BITS    = SPAN_BITS - LO_BITS;

	typedef enum logic [1:0] {
		OP_TO_CANON = 2'd0,
		OP_TO_RAW   = 2'd1,
		OP_ROW      = 2'd2,
		OP_UNUSED   = 2'd3
	} opcode_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_INVALID   = 2'd1,
		ST_MALFORMED = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		CONV_MID    = 2'd0,
		CONV_START  = 2'd1,
		CONV_END    = 2'd2,
		CONV_OFFSET = 2'd3
	} conv_t;

	localparam logic [2:0] CFG_CONVENTION = 3'd0;
	localparam logic [2:0] CFG_OFFSET     = 3'd1;
	localparam logic [2:0] CFG_SHUTTER    = 3'd2;
	localparam logic [2:0] CFG_SPAN       = 3'd3;
	localparam logic [2:0] CFG_DIRECTION  = 3'd4;
	localparam logic [2:0] CFG_ROWS       = 3'd5;

	typedef struct packed {
		logic [1:0]                  opcode;
		logic signed [TIME_BITS-1:0] time_ns;
		logic signed [TIME_BITS-1:0] duration_ns;
		logic [ROW_BITS-1:0]         row_index;
	} req_t;

	typedef struct packed {
		logic signed [TIME_BITS-1:0] result_ns;
		logic [1:0]                  status;
	} rsp_t;

	// classified word passed from front to back
	typedef struct packed {
		logic [TIME_BITS-1:0] value;
		status_t              status;
		logic                 need_div;
		logic [SPAN_BITS-1:0] span;
		logic [ROW_BITS-1:0]  k;
		logic [ROW_BITS-1:0]  den;
	} item_t;

	// one word in flight through the divider
	typedef struct packed {
		logic [TIME_BITS-1:0] value;
		status_t              status;
		logic                 need_div;
		logic [ROW_BITS-1:0]  den;
		logic [ROW_BITS-1:0]  rem;
		logic [TIME_BITS-1:0] nq;
	} div_t;

endpackage

// ===== hw/rtl/exposure_timestamp_corrector.sv =====
// Exposure timestamp corrector. One word is taken per cycle (start high while
// busy is low) and its result appears with done, in order, after the queue,
// the product and rounding stages, the 64-stage one-bit-per-stage divider used
// for rolling-shutter row instants and the output register. The receiver cannot
// stall. Every opcode takes the same path so ordering is kept. The back end drains the
// two-entry queue ahead of it every cycle, so busy never rises and words may
// follow back to back. Configuration writes are always ready and must happen
// while no word is in flight.
module exposure_timestamp_corrector import etc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  req_t        req,
	output logic        done,
	output rsp_t        result,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data
);

	item_t front_item;
	item_t queue_item;
	logic  queue_full;
	logic  queue_pop;
	logic  accept;

	assign cfg_ready = 1'b1;
	assign busy      = queue_full;
	assign accept    = start && !queue_full;

	etc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req       (req),
		.item      (front_item)
	);

	etc_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (accept),
		.wdata  (front_item),
		.full   (queue_full),
		.pop    (queue_pop),
		.rdata  (queue_item)
	);

	etc_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (queue_pop),
		.in_item  (queue_item),
		.done     (done),
		.result   (result)
	);

endmodule

// ===== hw/rtl/etc_front.sv =====
module etc_front import etc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data,
	input  req_t        req,
	output item_t       item
);

	logic [1:0]           convention_q;
	logic [TIME_BITS-1:0] offset_q;
	logic                 shutter_q;
	logic [SPAN_BITS-1:0] span_q;
	logic                 direction_q;
	logic [ROW_BITS-1:0]  rows_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			convention_q <= '0;
			offset_q     <= '0;
			shutter_q    <= 1'b0;
			span_q       <= '0;
			direction_q  <= 1'b0;
			rows_q       <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_CONVENTION: convention_q <= cfg_data[1:0];
				CFG_OFFSET:     offset_q     <= cfg_data;
				CFG_SHUTTER:    shutter_q    <= cfg_data[0];
				CFG_SPAN:       span_q       <= cfg_data[SPAN_BITS-1:0];
				CFG_DIRECTION:  direction_q  <= cfg_data[0];
				CFG_ROWS:       rows_q       <= cfg_data[ROW_BITS-1:0];
				default: ;
			endcase
		end
	end

	logic [TIME_BITS-1:0] t;
	logic [TIME_BITS-1:0] half;
	logic [TIME_BITS-1:0] shift;
	logic [ROW_BITS-1:0]  den;

	// classify the word and settle everything but the row product and division
	always_comb begin
		t     = req.time_ns;
		half  = {1'b0, req.duration_ns[TIME_BITS-1:1]};
		den   = rows_q - ROW_BITS'(1);
		shift = '0;
		item          = '0;
		item.span     = span_q;
		item.den      = den;
		item.k        = direction_q ? (den - req.row_index) : req.row_index;
		item.value    = t;
		item.status   = ST_OK;
		item.need_div = 1'b0;
		if (req.opcode == OP_ROW) begin
			if (!shutter_q) begin
				if (span_q != '0 || rows_q != '0) item.status = ST_MALFORMED;
			end else if (rows_q == '0) begin
				item.status = ST_MALFORMED;
			end else if (req.row_index >= rows_q) begin
				item.status = ST_INVALID;
			end else if (rows_q != ROW_BITS'(1)) begin
				item.need_div = 1'b1;
			end
		end else if (req.opcode == OP_UNUSED || req.duration_ns[TIME_BITS-1]) begin
			item.status = ST_INVALID;
		end else begin
			unique case (convention_q)
				CONV_MID:    shift = '0;
				CONV_START:  shift = half;
				CONV_END:    shift = '0 - half;
				CONV_OFFSET: shift = offset_q + half;
				default:     shift = '0;
			endcase
			item.value = (req.opcode == OP_TO_CANON) ? t + shift : t - shift;
		end
	end

endmodule

// ===== hw/rtl/etc_fifo.sv =====
`include "exposure_timestamp_corrector_macros.svh"

module etc_fifo import etc_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t wdata,
	output logic  full,
	output logic  pop,
	output item_t rdata
);

	item_t      mem_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] count_q;

	assign full  = (count_q == 2'd2);
	assign pop   = (count_q != 2'd0);
	assign rdata = mem_q[rd_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= wdata;
	end

	// pointers and fill level; back end drains every cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= 1'b0;
			rd_q    <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (pop)  rd_q <= ~rd_q;
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

	`ETC_ASSERT_NOW(a_no_overfill, clk, arst_n, full, !push, "push into full queue")
	`ETC_ASSERT_NOW(a_count_range, clk, arst_n, 1'b1, count_q != 2'd3, "queue count out of range")
	`ETC_ASSERT_NEXT(a_single_drain, clk, arst_n, push && !pop, count_q == 2'd1, "queue level wrong")

endmodule

// ===== hw/rtl/etc_back.sv =====
`include "exposure_timestamp_corrector_macros.svh"

module etc_back import etc_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	input  item_t in_item,
	output logic  done,
	output rsp_t  result
);

	localparam int BACK_LAT = DIV_STAGES + 4;

	// stage 1: partial products
	logic                      v_s1;
	item_t                     it_s1;
	logic [LO_BITS+ROW_BITS-1:0] plo_s1;
	logic [HI_BITS+ROW_BITS-1:0] phi_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else         v_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		it_s1  <= in_item;
		plo_s1 <= in_item.span[LO_BITS-1:0] * in_item.k;
		phi_s1 <= in_item.span[SPAN_BITS-1:LO_BITS] * in_item.k;
	end

	// stage 2: full product
	logic                 v_s2;
	item_t                it_s2;
	logic [PROD_BITS-1:0] prod_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else         v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		it_s2   <= it_s1;
		prod_s2 <= {phi_s1, {LO_BITS{1'b0}}} + PROD_BITS'(plo_s1);
	end

	// stage 3: overflow check and rounding bias
	logic ovf;
	logic v_s3;
	div_t d_s3;

	assign ovf = |prod_s2[PROD_BITS-1:SPAN_BITS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else         v_s3 <= v_s2;
	end

	always_ff @(posedge clk) begin
		d_s3.value    <= it_s2.value;
		d_s3.status   <= (it_s2.need_div && ovf) ? ST_INVALID : it_s2.status;
		d_s3.need_div <= it_s2.need_div;
		d_s3.den      <= it_s2.den;
		d_s3.rem      <= '0;
		d_s3.nq       <= {1'b0, prod_s2[SPAN_BITS-1:0]}
			+ TIME_BITS'(it_s2.den[ROW_BITS-1:1]);
	end

	// radix-2 restoring divider, one quotient bit per stage
	logic v_dq [DIV_STAGES+1];
	div_t d_dq [DIV_STAGES+1];

	assign v_dq[0] = v_s3;
	assign d_dq[0] = d_s3;

	for (genvar i = 0; i < DIV_STAGES; i++) begin : g_div
		logic [ROW_BITS:0] trial;
		logic              qbit;
		div_t              nxt;

		always_comb begin
			trial = {d_dq[i].rem, d_dq[i].nq[TIME_BITS-1]};
			qbit  = (trial >= {1'b0, d_dq[i].den});
			nxt   = d_dq[i];
			nxt.rem = qbit ? ROW_BITS'(trial - {1'b0, d_dq[i].den}) : trial[ROW_BITS-1:0];
			nxt.nq  = {d_dq[i].nq[TIME_BITS-2:0], qbit};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v_dq[i+1] <= 1'b0;
			else         v_dq[i+1] <= v_dq[i];
		end

		always_ff @(posedge clk) begin
			d_dq[i+1] <= nxt;
		end
	end

	// output register: zero on error, else add quotient to first-row instant when dividing
	div_t fin;
	assign fin = d_dq[DIV_STAGES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done <= 1'b0;
		else         done <= v_dq[DIV_STAGES];
	end

	always_ff @(posedge clk) begin
		result.status <= fin.status;
		if (fin.status != ST_OK)  result.result_ns <= '0;
		else if (fin.need_div)    result.result_ns <= fin.value + fin.nq;
		else                      result.result_ns <= fin.value;
	end

	`ETC_ASSERT_DELAY(a_fixed_latency, clk, arst_n, in_valid, BACK_LAT, done, "result missing")
	`ETC_ASSERT_NOW(a_err_zero, clk, arst_n, done && result.status != ST_OK, result.result_ns == '0, "error result not zero")
	`ETC_ASSERT_NOW(a_status_code, clk, arst_n, done, result.status != 2'd3, "bad status code")

endmodule

// ===== tb/exposure_timestamp_corrector_checker.sv =====
`timescale 1ns / 100ps

module exposure_timestamp_checker import etc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  req_t        req,
	input  logic        done,
	input  rsp_t        result,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data,
	output int          mismatches,
	output int          outstanding
);

	// shadow copy of the configuration registers
	conv_t                 conv_sel;
	logic [TIME_BITS-1:0]  frame_shift;
	logic                  rolling;
	logic [SPAN_BITS-1:0]  span_ns;
	logic                  bottom_up;
	logic [ROW_BITS-1:0]   rows;

	rsp_t expected_words[$];

	function automatic rsp_t make_word(logic [TIME_BITS-1:0] value, status_t st);
		rsp_t w;
		w.result_ns = (st == ST_OK) ? value : '0;
		w.status    = st;
		return w;
	endfunction

	// instant of one row of a rolling-shutter readout
	function automatic rsp_t row_instant(logic [TIME_BITS-1:0] first,
		logic [ROW_BITS-1:0] row);
		logic [ROW_BITS-1:0]  den;
		logic [ROW_BITS-1:0]  k;
		logic [79:0]          prod;
		logic [TIME_BITS-1:0] quot;
		if (!rolling) begin
			if (span_ns != 0 || rows != 0)
				return make_word('0, ST_MALFORMED);
			return make_word(first, ST_OK);
		end
		if (rows == 0)
			return make_word('0, ST_MALFORMED);
		if (row >= rows)
			return make_word('0, ST_INVALID);
		if (rows == 1)
			return make_word(first, ST_OK);
		den  = rows - ROW_BITS'(1);
		k    = bottom_up ? den - row : row;
		prod = 80'(span_ns) * 80'(k);
		if (prod > 80'h7FFF_FFFF_FFFF_FFFF)
			return make_word('0, ST_INVALID);
		quot = (prod[63:0] + 64'(den >> 1)) / 64'(den);
		return make_word(first + quot, ST_OK);
	endfunction

	// expected result word for one request word
	function automatic rsp_t corrected_time(req_t r);
		logic [TIME_BITS-1:0] t;
		logic [TIME_BITS-1:0] half;
		logic                 fwd;
		t = r.time_ns;
		half = {1'b0, r.duration_ns[63:1]};
		fwd = (r.opcode == OP_TO_CANON);
		if (r.opcode == OP_ROW)
			return row_instant(t, r.row_index);
		if (r.opcode == OP_UNUSED || r.duration_ns[63])
			return make_word('0, ST_INVALID);
		case (conv_sel)
			CONV_MID:   return make_word(t, ST_OK);
			CONV_START: return make_word(fwd ? t + half : t - half, ST_OK);
			CONV_END:   return make_word(fwd ? t - half : t + half, ST_OK);
			default:    return make_word(fwd ? t + frame_shift + half
				: t - frame_shift - half, ST_OK);
		endcase
	endfunction

	always @(posedge clk or negedge arst_n) begin
		rsp_t want;
		if (!arst_n) begin
			conv_sel    <= CONV_MID;
			frame_shift <= '0;
			rolling     <= 1'b0;
			span_ns     <= '0;
			bottom_up   <= 1'b0;
			rows        <= '0;
			expected_words.delete();
			mismatches  = 0;
			outstanding = 0;
		end else begin
			// register writes
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_CONVENTION: conv_sel    <= conv_t'(cfg_data[1:0]);
					CFG_OFFSET:     frame_shift <= cfg_data;
					CFG_SHUTTER:    rolling     <= cfg_data[0];
					CFG_SPAN:       span_ns     <= cfg_data[SPAN_BITS-1:0];
					CFG_DIRECTION:  bottom_up   <= cfg_data[0];
					CFG_ROWS:       rows        <= cfg_data[ROW_BITS-1:0];
					default: ;
				endcase
			end
			// accepted request words
			if (start && !busy)
				expected_words.push_back(corrected_time(req));
			// result words, in order
			if (done) begin
				if (expected_words.size() == 0) begin
					$error("result word with nothing expected: result_ns %0d status %0d",
						result.result_ns, result.status);
					mismatches++;
				end else begin
					want = expected_words.pop_front();
					if (result.result_ns !== want.result_ns) begin
						$error("result_ns: expected %0d, actual %0d",
							want.result_ns, result.result_ns);
						mismatches++;
					end
					if (result.status !== want.status) begin
						$error("status: expected %0d, actual %0d",
							want.status, result.status);
						mismatches++;
					end
				end
			end
			outstanding = expected_words.size();
		end
	end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
	import etc_pkg::*;

	localparam int PHASES     = 12;
	localparam int PER_PHASE  = 70;
	localparam int DRAIN_WAIT = 80;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	req_t        req = '0;
	logic        done;
	rsp_t        result;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = '0;
	logic [63:0] cfg_data = '0;
	int          mismatches;
	int          outstanding;
	logic        quiet = 1'b0;

	// rows in the current setting, for aiming row indexes
	logic [ROW_BITS-1:0] cur_rows = '0;

	exposure_timestamp_corrector dut (
		.clk, .arst_n, .start, .busy, .req, .done, .result,
		.cfg_valid, .cfg_ready, .cfg_index, .cfg_data
	);

	exposure_timestamp_checker checker_i (
		.clk, .arst_n, .start, .busy, .req, .done, .result,
		.cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
		.mismatches, .outstanding
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	initial begin
		#1ms;
		$display("CHECK FAILED");
		$finish;
	end

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// one register write; valid is left high for the caller to drop
	task automatic write_reg(logic [2:0] idx, logic [63:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		if (idx == CFG_ROWS)
			cur_rows = data[ROW_BITS-1:0];
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic write_all(logic [1:0] conv, logic [63:0] offs, logic shut,
		logic [62:0] span, logic dir, logic [15:0] nrows);
		write_reg(CFG_CONVENTION, 64'(conv));
		write_reg(CFG_OFFSET, offs);
		write_reg(CFG_SHUTTER, 64'(shut));
		write_reg(CFG_SPAN, 64'(span));
		write_reg(CFG_DIRECTION, 64'(dir));
		write_reg(CFG_ROWS, 64'(nrows));
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// present one request word and hold it until taken
	task automatic send_word(opcode_t op, logic [63:0] t, logic [63:0] dur,
		logic [15:0] row);
		if (!quiet && $urandom_range(0, 5) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		start <= 1'b1;
		req   <= '{opcode: op, time_ns: t, duration_ns: dur, row_index: row};
		do @(posedge clk); while (busy);
	endtask

	task automatic send_random();
		opcode_t     op;
		logic [63:0] dur;
		logic [15:0] row;
		op = opcode_t'($urandom_range(0, 9) == 0 ? 3 : $urandom_range(0, 2));
		dur = rand64();
		if ($urandom_range(0, 4) != 0)
			dur[63] = 1'b0;
		if ($urandom_range(0, 2) == 0)
			dur = dur >> $urandom_range(0, 63);
		if (cur_rows != 0 && $urandom_range(0, 4) != 0)
			row = 16'($urandom_range(0, cur_rows - 1));
		else
			row = 16'($urandom);
		send_word(op, rand64(), dur, row);
	endtask

	task automatic wait_idle();
		start <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	localparam logic [62:0] SPAN_MAX = {63{1'b1}};
	localparam logic [63:0] T_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] T_MIN = 64'h8000_0000_0000_0000;

	initial begin
		logic [62:0] span;
		logic [15:0] nrows;
		logic        shut;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset setting: mid convention, global shutter, nothing configured
		send_word(OP_TO_CANON, T_MAX, T_MAX, '0);
		send_word(OP_TO_RAW, T_MIN, 64'd0, '0);
		send_word(OP_UNUSED, 64'd5, 64'd10, '0);
		send_word(OP_TO_CANON, 64'd100, T_MIN, '0);
		send_word(OP_ROW, T_MIN, T_MIN, 16'hFFFF);
		wait_idle();

		for (int p = 1; p < PHASES; p++) begin
			case (p)
				1: write_all(CONV_START, 64'd0, 1'b1, SPAN_MAX, 1'b0, 16'hFFFF);
				2: write_all(CONV_END, T_MAX, 1'b0, 63'd1000, 1'b0, 16'd0);
				3: write_all(CONV_OFFSET, T_MIN, 1'b1, 63'd500, 1'b1, 16'd0);
				4: write_all(CONV_OFFSET, T_MAX, 1'b1, SPAN_MAX, 1'b1, 16'd1);
				5: write_all(CONV_START, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, SPAN_MAX,
					1'b1, 16'd2);
				6: write_all(CONV_END, 64'd0, 1'b0, 63'd0, 1'b1, 16'd1);
				default: begin
					shut  = $urandom_range(0, 1);
					span  = 63'(rand64()) >> $urandom_range(0, 62);
					nrows = ($urandom_range(0, 2) == 0) ? 16'($urandom)
						: 16'($urandom_range(0, 40));
					if (!shut && $urandom_range(0, 1) == 0) begin
						span  = '0;
						nrows = '0;
					end
					write_all(2'($urandom), rand64(), shut, span, 1'($urandom), nrows);
				end
			endcase

			// corner words for the settings above
			case (p)
				1: begin
					send_word(OP_ROW, 64'd7, 64'd0, 16'd0);
					send_word(OP_ROW, 64'd7, 64'd0, 16'd1);
					send_word(OP_ROW, 64'd7, 64'd0, 16'd65534);
					send_word(OP_ROW, 64'd7, 64'd0, 16'hFFFF);
					send_word(OP_TO_CANON, T_MAX, T_MAX, '0);
					send_word(OP_TO_RAW, T_MIN, T_MAX, '0);
				end
				2: begin
					send_word(OP_ROW, 64'd1, 64'd0, 16'd0);
					send_word(OP_TO_CANON, T_MIN, T_MAX, '0);
				end
				3: begin
					send_word(OP_ROW, 64'd1, 64'd0, 16'd0);
					send_word(OP_TO_CANON, T_MIN, 64'd3, '0);
					send_word(OP_TO_RAW, T_MIN, 64'd3, '0);
				end
				4: begin
					send_word(OP_ROW, T_MAX, 64'd0, 16'd0);
					send_word(OP_ROW, T_MAX, 64'd0, 16'd1);
				end
				5: begin
					send_word(OP_ROW, T_MAX, 64'd0, 16'd0);
					send_word(OP_ROW, T_MAX, 64'd0, 16'd1);
				end
				6: send_word(OP_ROW, T_MIN, 64'd0, 16'd0);
				default: ;
			endcase

			if (p == PHASES - 1)
				quiet = 1'b1;
			repeat (PER_PHASE + (p == PHASES - 1 ? 100 : 0)) send_random();
			wait_idle();
		end

		if (mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
